// ===== design/page_bitmap_allocator_top_macros.svh =====
// Assertion macros shared by the allocator top level.
`ifndef PAGE_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PBA_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define PBA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/pba_pkg.sv =====
// Types and codes shared by the page allocator modules.
package pba_pkg;

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_RESIZE  = 2'd1;
    localparam logic [1:0] CMD_FREE    = 2'd2;
    localparam logic [1:0] CMD_INVALID = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_SHRINK  = 2'd3;

    localparam logic [10:0] HEAP_RESET = 11'd1024;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_FIND_RD, S_FIND_EV, S_CHK_RD, S_CHK_EV,
        S_MARK_SETUP, S_CLR_SETUP, S_RNG_RD, S_RNG_EV, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE, DP_INIT, DP_LOAD, DP_NOSPACE, DP_OOB, DP_SHRINK,
        DP_FIND_INIT, DP_FIND_EV, DP_CHK_INIT, DP_CHK_EV,
        DP_MARK_IDX, DP_MARK_START, DP_CLEAR_INIT, DP_FREE_INIT, DP_RNG_EV
    } dp_op_t;

    typedef enum logic [1:0] {
        RM_MARK, RM_CLEAR, RM_FREE
    } rng_mode_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_oob;
        logic       shrink;
        logic       grow;
        logic       fits;
        logic       cnt_zero;
        logic       ptr_done;
        logic       hit;
        logic       blocked;
        logic       mode_clear;
        logic       init_last;
    } dp_stat_t;

endpackage

// ===== design/pba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pba_ctrl.sv =====
// Command sequencer for the page allocator.
module pba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pba_pkg::dp_stat_t stat,
    output pba_pkg::dp_op_t   op,
    output logic              busy,
    output logic              done
);

    pba_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pba_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pba_pkg::S_INIT:
                if (stat.init_last) state_next = pba_pkg::S_IDLE;
            pba_pkg::S_IDLE:
                if (start) state_next = pba_pkg::S_DECODE;
            pba_pkg::S_DECODE:
            begin
                case (stat.cmd)
                    pba_pkg::CMD_RESERVE:
                        state_next = stat.cnt_zero ? pba_pkg::S_DONE : pba_pkg::S_FIND_RD;
                    pba_pkg::CMD_RESIZE:
                        if (stat.idx_oob || stat.shrink) state_next = pba_pkg::S_DONE;
                        else if (stat.grow && !stat.fits) state_next = pba_pkg::S_FIND_RD;
                        else if (stat.grow) state_next = pba_pkg::S_CHK_RD;
                        else state_next = pba_pkg::S_RNG_RD;
                    pba_pkg::CMD_FREE:
                        state_next = stat.idx_oob ? pba_pkg::S_DONE : pba_pkg::S_RNG_RD;
                    default:
                        state_next = pba_pkg::S_DONE;
                endcase
            end
            pba_pkg::S_FIND_RD:
                state_next = stat.ptr_done ? pba_pkg::S_DONE : pba_pkg::S_FIND_EV;
            pba_pkg::S_FIND_EV:
                if (!stat.hit) state_next = pba_pkg::S_FIND_RD;
                else if (stat.cmd == pba_pkg::CMD_RESIZE) state_next = pba_pkg::S_CLR_SETUP;
                else state_next = pba_pkg::S_MARK_SETUP;
            pba_pkg::S_CHK_RD:
                state_next = stat.ptr_done ? pba_pkg::S_RNG_RD : pba_pkg::S_CHK_EV;
            pba_pkg::S_CHK_EV:
                state_next = stat.blocked ? pba_pkg::S_FIND_RD : pba_pkg::S_CHK_RD;
            pba_pkg::S_MARK_SETUP, pba_pkg::S_CLR_SETUP:
                state_next = pba_pkg::S_RNG_RD;
            pba_pkg::S_RNG_RD:
                if (!stat.ptr_done) state_next = pba_pkg::S_RNG_EV;
                else if (stat.mode_clear) state_next = pba_pkg::S_MARK_SETUP;
                else state_next = pba_pkg::S_DONE;
            pba_pkg::S_RNG_EV:
                state_next = pba_pkg::S_RNG_RD;
            pba_pkg::S_DONE:
                state_next = pba_pkg::S_IDLE;
            default:
                state_next = pba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op = pba_pkg::DP_NONE;
        case (state_reg)
            pba_pkg::S_INIT:
                op = pba_pkg::DP_INIT;
            pba_pkg::S_IDLE:
                if (start) op = pba_pkg::DP_LOAD;
            pba_pkg::S_DECODE:
            begin
                case (stat.cmd)
                    pba_pkg::CMD_RESERVE:
                        op = stat.cnt_zero ? pba_pkg::DP_NOSPACE : pba_pkg::DP_FIND_INIT;
                    pba_pkg::CMD_RESIZE:
                        if (stat.idx_oob) op = pba_pkg::DP_OOB;
                        else if (stat.shrink) op = pba_pkg::DP_SHRINK;
                        else if (stat.grow && !stat.fits) op = pba_pkg::DP_FIND_INIT;
                        else if (stat.grow) op = pba_pkg::DP_CHK_INIT;
                        else op = pba_pkg::DP_MARK_IDX;
                    pba_pkg::CMD_FREE:
                        op = stat.idx_oob ? pba_pkg::DP_OOB : pba_pkg::DP_FREE_INIT;
                    default:
                        op = pba_pkg::DP_OOB;
                endcase
            end
            pba_pkg::S_FIND_RD:
                if (stat.ptr_done) op = pba_pkg::DP_NOSPACE;
            pba_pkg::S_FIND_EV:
                op = pba_pkg::DP_FIND_EV;
            pba_pkg::S_CHK_RD:
                if (stat.ptr_done) op = pba_pkg::DP_MARK_IDX;
            pba_pkg::S_CHK_EV:
                op = stat.blocked ? pba_pkg::DP_FIND_INIT : pba_pkg::DP_CHK_EV;
            pba_pkg::S_MARK_SETUP:
                op = pba_pkg::DP_MARK_START;
            pba_pkg::S_CLR_SETUP:
                op = pba_pkg::DP_CLEAR_INIT;
            pba_pkg::S_RNG_EV:
                op = pba_pkg::DP_RNG_EV;
            default:
                op = pba_pkg::DP_NONE;
        endcase
    end

    assign busy = (state_reg != pba_pkg::S_IDLE);
    assign done = (state_reg == pba_pkg::S_DONE);

endmodule

// ===== design/pba_datapath.sv =====
// Used map, scan pointers, counters and result registers of the allocator.
module pba_datapath #(
    parameter int MAP_PAGES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pba_pkg::dp_op_t   op,
    output pba_pkg::dp_stat_t stat,
    input  logic [1:0]        command,
    input  logic [9:0]        page_index,
    input  logic [10:0]       old_count,
    input  logic [10:0]       count,
    input  logic              cfg_write,
    input  logic [10:0]       cfg_data,
    output logic [1:0]        status,
    output logic [9:0]        start_page,
    output logic              relocated,
    output logic [10:0]       double_freed,
    output logic [10:0]       pages_used
);

    localparam int AW = $clog2(MAP_PAGES);
    localparam int W  = ((AW > 11) ? AW : 11) + 2;
    localparam logic [W-1:0] MAPW = W'(MAP_PAGES);

    logic [10:0]        heap_reg;
    logic [1:0]         cmd_reg;
    logic [W-1:0]       idx_reg, oldc_reg, cnt_reg, cap_reg;
    logic [W-1:0]       ptr_reg, ptr_next, end_reg, end_next;
    logic [W-1:0]       run_reg, run_next, first_reg, first_next;
    logic [W-1:0]       used_reg, used_next, dfree_reg, dfree_next;
    logic [W-1:0]       start_reg, start_next;
    logic [AW-1:0]      hint_reg, hint_next;
    logic [1:0]         status_reg, status_next;
    logic               reloc_reg, reloc_next;
    pba_pkg::rng_mode_t mode_reg, mode_next;

    logic               ram_we, ram_wdata, rd_used;
    logic [W-1:0]       sum_idx_cnt, sum_idx_old, sum_start_cnt, heap_w, cap_in;

    pba_ram #(.WIDTH(1), .DEPTH(MAP_PAGES)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_used)
    );

    assign sum_idx_cnt   = idx_reg + cnt_reg;
    assign sum_idx_old   = idx_reg + oldc_reg;
    assign sum_start_cnt = start_reg + cnt_reg;
    assign heap_w        = W'(heap_reg);
    assign cap_in        = (heap_w > MAPW) ? MAPW : heap_w;

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.idx_oob    = (idx_reg >= cap_reg);
        stat.shrink     = (cnt_reg < oldc_reg);
        stat.grow       = (cnt_reg > oldc_reg);
        stat.fits       = (sum_idx_cnt <= cap_reg);
        stat.cnt_zero   = (cnt_reg == '0);
        stat.ptr_done   = (ptr_reg >= end_reg);
        stat.hit        = !rd_used && (run_reg + W'(1) == cnt_reg);
        stat.blocked    = rd_used;
        stat.mode_clear = (mode_reg == pba_pkg::RM_CLEAR);
        stat.init_last  = (ptr_reg == MAPW - W'(1));
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        run_next    = run_reg;
        first_next  = first_reg;
        used_next   = used_reg;
        dfree_next  = dfree_reg;
        start_next  = start_reg;
        hint_next   = hint_reg;
        status_next = status_reg;
        reloc_next  = reloc_reg;
        mode_next   = mode_reg;
        ram_we      = 1'b0;
        ram_wdata   = 1'b0;
        case (op)
            pba_pkg::DP_INIT:
            begin
                ram_we   = 1'b1;
                ptr_next = stat.init_last ? '0 : ptr_reg + W'(1);
            end
            pba_pkg::DP_LOAD:
            begin
                status_next = pba_pkg::ST_OK;
                start_next  = '0;
                reloc_next  = 1'b0;
                dfree_next  = '0;
                mode_next   = pba_pkg::RM_MARK;
            end
            pba_pkg::DP_NOSPACE:
            begin
                status_next = pba_pkg::ST_NOSPACE;
                start_next  = '0;
            end
            pba_pkg::DP_OOB:
                status_next = pba_pkg::ST_RANGE;
            pba_pkg::DP_SHRINK:
                status_next = pba_pkg::ST_SHRINK;
            pba_pkg::DP_FIND_INIT:
            begin
                ptr_next = W'(hint_reg);
                end_next = cap_reg;
                run_next = '0;
            end
            pba_pkg::DP_FIND_EV:
            begin
                if (rd_used)
                begin
                    run_next = '0;
                end
                else
                begin
                    if (run_reg == '0) first_next = ptr_reg;
                    run_next = run_reg + W'(1);
                    if (stat.hit) start_next = (run_reg == '0) ? ptr_reg : first_reg;
                end
                ptr_next = ptr_reg + W'(1);
            end
            pba_pkg::DP_CHK_INIT:
            begin
                ptr_next = sum_idx_old;
                end_next = sum_idx_cnt;
            end
            pba_pkg::DP_CHK_EV:
                ptr_next = ptr_reg + W'(1);
            pba_pkg::DP_MARK_IDX:
            begin
                start_next = idx_reg;
                ptr_next   = idx_reg;
                end_next   = (sum_idx_cnt > cap_reg) ? cap_reg : sum_idx_cnt;
                mode_next  = pba_pkg::RM_MARK;
            end
            pba_pkg::DP_MARK_START:
            begin
                ptr_next  = start_reg;
                end_next  = (sum_start_cnt > cap_reg) ? cap_reg : sum_start_cnt;
                mode_next = pba_pkg::RM_MARK;
            end
            pba_pkg::DP_CLEAR_INIT:
            begin
                reloc_next = 1'b1;
                ptr_next   = idx_reg;
                end_next   = (sum_idx_old > cap_reg) ? cap_reg : sum_idx_old;
                mode_next  = pba_pkg::RM_CLEAR;
            end
            pba_pkg::DP_FREE_INIT:
            begin
                if (idx_reg < W'(hint_reg)) hint_next = idx_reg[AW-1:0];
                ptr_next  = idx_reg;
                end_next  = (sum_idx_cnt > cap_reg) ? cap_reg : sum_idx_cnt;
                mode_next = pba_pkg::RM_FREE;
            end
            pba_pkg::DP_RNG_EV:
            begin
                if (mode_reg == pba_pkg::RM_MARK)
                begin
                    ram_we    = !rd_used;
                    ram_wdata = 1'b1;
                    if (!rd_used) used_next = used_reg + W'(1);
                end
                else
                begin
                    ram_we = rd_used;
                    if (rd_used) used_next = used_reg - W'(1);
                    else if (mode_reg == pba_pkg::RM_FREE) dfree_next = dfree_reg + W'(1);
                end
                ptr_next = ptr_reg + W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= pba_pkg::HEAP_RESET;
            ptr_reg  <= '0;
            hint_reg <= '0;
            used_reg <= '0;
            mode_reg <= pba_pkg::RM_MARK;
        end
        else
        begin
            if (cfg_write) heap_reg <= cfg_data;
            ptr_reg  <= ptr_next;
            hint_reg <= hint_next;
            used_reg <= used_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == pba_pkg::DP_LOAD)
        begin
            cmd_reg  <= command;
            idx_reg  <= W'(page_index);
            oldc_reg <= W'(old_count);
            cnt_reg  <= W'(count);
            cap_reg  <= cap_in;
        end
        end_reg    <= end_next;
        run_reg    <= run_next;
        first_reg  <= first_next;
        dfree_reg  <= dfree_next;
        start_reg  <= start_next;
        status_reg <= status_next;
        reloc_reg  <= reloc_next;
    end

    assign status       = status_reg;
    assign start_page   = start_reg[9:0];
    assign relocated    = reloc_reg;
    assign double_freed = dfree_reg[10:0];
    assign pages_used   = used_reg[10:0];

endmodule

// ===== design/page_bitmap_allocator_top.sv =====
// Top level of the bitmap first-fit page allocator.
// After reset the block sweeps the used map clear, one page a cycle, with busy high;
// cfg_write writes are taken during that time. A command is taken when start is high and
// busy low, and its result shows on the result ports for one cycle with done high; it
// cannot be held off. The map is a one-bit RAM with a registered read, so each page a
// command visits is first read, then evaluated and written back.
module page_bitmap_allocator_top #(
    parameter int MAP_PAGES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [9:0]  page_index,
    input  logic [10:0] old_count,
    input  logic [10:0] count,
    input  logic        cfg_write,
    input  logic [10:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  start_page,
    output logic        relocated,
    output logic [10:0] double_freed,
    output logic [10:0] pages_used
);

`include "page_bitmap_allocator_top_macros.svh"

    pba_pkg::dp_op_t   op;
    pba_pkg::dp_stat_t stat;

    pba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    pba_datapath #(.MAP_PAGES(MAP_PAGES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .command      (command),
        .page_index   (page_index),
        .old_count    (old_count),
        .count        (count),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .status       (status),
        .start_page   (start_page),
        .relocated    (relocated),
        .double_freed (double_freed),
        .pages_used   (pages_used)
    );

    `PBA_ASSERT_NEXT(a_no_instant_result, start && !busy, !done, "result right after transfer")
    `PBA_ASSERT_NOW(a_done_while_busy, done, busy, "result strobe while idle")
    `PBA_ASSERT_NOW(a_reloc_ok, done && relocated, status == pba_pkg::ST_OK, "relocation not ok")
    `PBA_ASSERT_NOW(a_fail_zero_start, done && status != pba_pkg::ST_OK, start_page == 10'd0,
        "failed command with start page")

endmodule

// ===== dv/page_bitmap_allocator_top_tb.sv =====
// Self-checking testbench for the bitmap first-fit page allocator top level.
module page_bitmap_allocator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  start_page;
        logic        relocated;
        logic [10:0] double_freed;
        logic [10:0] pages_used;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [9:0]  page_index;
    logic [10:0] old_count;
    logic [10:0] count;
    logic        cfg_write;
    logic [10:0] cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  start_page;
    logic        relocated;
    logic [10:0] double_freed;
    logic [10:0] pages_used;

    // Predictor state
    bit          page_used [1024];
    int unsigned scan_hint;
    int unsigned used_pages;
    int unsigned heap_size;

    alloc_result_t expected_results [$];
    int          failures;
    int          items_sent;
    int          results_seen;
    int          relocations_seen;
    int          double_frees_seen;

    // Live runs, used to build well-formed resize and free commands
    int unsigned run_first [$];
    int unsigned run_len [$];

    page_bitmap_allocator_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .page_index(page_index), .old_count(old_count), .count(count),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done), .status(status),
        .start_page(start_page), .relocated(relocated), .double_freed(double_freed),
        .pages_used(pages_used)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned heap_cap();
        return (heap_size < 1024) ? heap_size : 1024;
    endfunction

    function automatic void mark_pages(int unsigned first, int unsigned len, int unsigned cap);
        for (int unsigned p = first; p < first + len && p < cap; p++)
        begin
            if (!page_used[p])
            begin
                page_used[p] = 1'b1;
                used_pages++;
            end
        end
    endfunction

    function automatic void clear_pages(int unsigned first, int unsigned len, int unsigned cap);
        for (int unsigned p = first; p < first + len && p < cap; p++)
        begin
            if (page_used[p])
            begin
                page_used[p] = 1'b0;
                used_pages--;
            end
        end
    endfunction

    function automatic bit first_fit(int unsigned len, int unsigned cap, output int unsigned at);
        int unsigned run;
        int unsigned first;
        run = 0;
        first = 0;
        at = 0;
        if (len == 0)
            return 1'b0;
        for (int unsigned p = scan_hint; p < cap; p++)
        begin
            if (!page_used[p])
            begin
                if (run == 0)
                    first = p;
                run++;
                if (run == len)
                begin
                    at = first;
                    return 1'b1;
                end
            end
            else
                run = 0;
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t predict_alloc(logic [1:0] cmd, logic [9:0] idx_v,
                                                    logic [10:0] oldc_v, logic [10:0] cnt_v);
        alloc_result_t r;
        int unsigned cap;
        int unsigned idx;
        int unsigned oldc;
        int unsigned cnt;
        int unsigned at;
        int unsigned dfree;
        bit in_place;
        cap = heap_cap();
        idx = 32'(idx_v);
        oldc = 32'(oldc_v);
        cnt = 32'(cnt_v);
        at = 0;
        dfree = 0;
        r.status = pba_pkg::ST_OK;
        r.relocated = 1'b0;
        if (cmd == pba_pkg::CMD_RESERVE)
        begin
            if (first_fit(cnt, cap, at))
                mark_pages(at, cnt, cap);
            else
                r.status = pba_pkg::ST_NOSPACE;
        end
        else if (cmd == pba_pkg::CMD_RESIZE)
        begin
            if (idx >= cap)
                r.status = pba_pkg::ST_RANGE;
            else if (cnt < oldc)
                r.status = pba_pkg::ST_SHRINK;
            else
            begin
                in_place = 1'b1;
                if (cnt > oldc)
                begin
                    if (idx + cnt > cap)
                        in_place = 1'b0;
                    else
                        for (int unsigned p = idx + oldc; p < idx + cnt; p++)
                            if (page_used[p])
                                in_place = 1'b0;
                end
                if (in_place)
                begin
                    at = idx;
                    mark_pages(idx, cnt, cap);
                end
                else if (first_fit(cnt, cap, at))
                begin
                    clear_pages(idx, oldc, cap);
                    mark_pages(at, cnt, cap);
                    r.relocated = 1'b1;
                end
                else
                begin
                    r.status = pba_pkg::ST_NOSPACE;
                    at = 0;
                end
            end
        end
        else if (cmd == pba_pkg::CMD_FREE)
        begin
            if (idx >= cap)
                r.status = pba_pkg::ST_RANGE;
            else
            begin
                if (idx < scan_hint)
                    scan_hint = idx;
                for (int unsigned p = idx; p < idx + cnt && p < cap; p++)
                begin
                    if (page_used[p])
                    begin
                        page_used[p] = 1'b0;
                        used_pages--;
                    end
                    else
                        dfree++;
                end
            end
        end
        else
            r.status = pba_pkg::ST_RANGE;
        r.start_page = at[9:0];
        r.double_freed = dfree[10:0];
        r.pages_used = used_pages[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, field, got, want);
        failures++;
    endtask

    // Check every result strobe against the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, pending", 0, 0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (start_page !== want.start_page)
                    report_mismatch("start_page", start_page, want.start_page);
                if (relocated !== want.relocated)
                    report_mismatch("relocated", relocated, want.relocated);
                if (double_freed !== want.double_freed)
                    report_mismatch("double_freed", double_freed, want.double_freed);
                if (pages_used !== want.pages_used)
                    report_mismatch("pages_used", pages_used, want.pages_used);
                if (want.relocated)
                    relocations_seen++;
                if (want.double_freed != 0)
                    double_frees_seen++;
            end
        end
    end

    task automatic send_command(logic [1:0] cmd, logic [9:0] idx, logic [10:0] oldc,
                                logic [10:0] cnt, output alloc_result_t r);
        @(negedge clk);
        start = 1'b1;
        command = cmd;
        page_index = idx;
        old_count = oldc;
        count = cnt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_alloc(cmd, idx, oldc, cnt);
        expected_results.push_back(r);
        items_sent++;
    endtask

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 50)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 60);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Hold off until every expected result has arrived
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        wait (expected_results.size() == 0);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic set_heap(logic [10:0] pages);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_data = pages;
        @(negedge clk);
        cfg_write = 1'b0;
        heap_size = 32'(pages);
        run_first.delete();
        run_len.delete();
    endtask

    task automatic directed_cmd(logic [1:0] cmd, int idx, int oldc, int cnt);
        alloc_result_t r;
        send_command(cmd, idx[9:0], oldc[10:0], cnt[10:0], r);
        idle_gap();
    endtask

    task automatic test_full_heap_cases();
        set_heap(11'd2047);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 0);         // zero length fails
        directed_cmd(pba_pkg::CMD_RESERVE, 1023, 2047, 1);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 1024);      // no fitting run
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 3);         // pages 1..3
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 2);         // pages 4..5
        directed_cmd(pba_pkg::CMD_RESIZE, 1, 3, 2);          // shrink refused
        directed_cmd(pba_pkg::CMD_RESIZE, 1, 3, 3);          // same size, in place
        directed_cmd(pba_pkg::CMD_RESIZE, 4, 2, 6);          // grow in place
        directed_cmd(pba_pkg::CMD_RESIZE, 1, 3, 5);          // blocked, relocate
        directed_cmd(pba_pkg::CMD_FREE, 0, 0, 8);            // partly already free
        directed_cmd(pba_pkg::CMD_FREE, 1023, 0, 2047);      // runs past the capacity
        directed_cmd(pba_pkg::CMD_INVALID, 1023, 2047, 2047);
        drain();
    endtask

    task automatic test_small_heap_cases();
        set_heap(11'd16);
        directed_cmd(pba_pkg::CMD_RESIZE, 20, 1, 2);         // index past capacity
        directed_cmd(pba_pkg::CMD_FREE, 1023, 0, 1);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 17);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 4);
        directed_cmd(pba_pkg::CMD_RESIZE, 12, 4, 8);         // grow past capacity
        directed_cmd(pba_pkg::CMD_RESIZE, 0, 2047, 2047);    // same size, clipped mark
        directed_cmd(pba_pkg::CMD_FREE, 10, 0, 100);         // ignores pages past capacity
        drain();
        set_heap(11'd0);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 1);
        directed_cmd(pba_pkg::CMD_RESIZE, 0, 0, 1);
        directed_cmd(pba_pkg::CMD_FREE, 0, 0, 1);
        drain();
        set_heap(11'd1);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 1);
        directed_cmd(pba_pkg::CMD_RESERVE, 0, 0, 1);
        directed_cmd(pba_pkg::CMD_FREE, 0, 0, 2);
        drain();
    endtask

    task automatic random_item();
        alloc_result_t r;
        int cap;
        int pick;
        int k;
        int len;
        int cnt;
        cap = heap_cap();
        pick = $urandom_range(0, 99);
        if (run_first.size() == 0 && pick < 95)
            pick = 0;
        if (pick < 45)
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                cnt = $urandom_range(1, (cap / 4 > 1) ? cap / 4 : 1);
            else if (k < 85)
                cnt = $urandom_range(1, (cap > 1) ? cap : 1);
            else if (k < 95)
                cnt = 0;
            else
                cnt = $urandom_range(0, 2047);
            send_command(pba_pkg::CMD_RESERVE, 10'($urandom_range(0, 1023)),
                         11'($urandom_range(0, 2047)), 11'(cnt), r);
            if (r.status == pba_pkg::ST_OK)
            begin
                run_first.push_back(32'(r.start_page));
                run_len.push_back(32'(cnt));
            end
        end
        else if (pick < 70)
        begin
            k = $urandom_range(0, run_first.size() - 1);
            len = int'(run_len[k]);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                cnt = len;
            else if (pick < 75)
                cnt = len + $urandom_range(1, 4);
            else if (pick < 90)
                cnt = (len > 0) ? len - 1 : 0;
            else
                cnt = $urandom_range(0, 2047);
            send_command(pba_pkg::CMD_RESIZE, 10'(run_first[k]), 11'(len), 11'(cnt), r);
            if (r.status == pba_pkg::ST_OK)
            begin
                run_first[k] = 32'(r.start_page);
                run_len[k] = 32'(cnt);
            end
        end
        else if (pick < 95)
        begin
            k = $urandom_range(0, run_first.size() - 1);
            cnt = ($urandom_range(0, 99) < 80) ? int'(run_len[k]) : $urandom_range(0, 8);
            send_command(pba_pkg::CMD_FREE, 10'(run_first[k]), 11'($urandom_range(0, 2047)),
                         11'(cnt), r);
            run_first.delete(k);
            run_len.delete(k);
        end
        else
            send_command(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                         11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), r);
        idle_gap();
    endtask

    task automatic test_random_heap(logic [10:0] pages, int items);
        set_heap(pages);
        for (int i = 0; i < items; i++)
        begin
            random_item();
            if (i % 150 == 149)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = pba_pkg::CMD_RESERVE;
        page_index = '0;
        old_count = '0;
        count = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        failures = 0;
        items_sent = 0;
        results_seen = 0;
        relocations_seen = 0;
        double_frees_seen = 0;
        for (int p = 0; p < 1024; p++)
            page_used[p] = 1'b0;
        scan_hint = 0;
        used_pages = 0;
        heap_size = 32'(pba_pkg::HEAP_RESET);
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_full_heap_cases();
        test_small_heap_cases();
        test_random_heap(11'd8, 320);
        test_random_heap(11'd24, 320);
        test_random_heap(11'd48, 320);
        test_random_heap(11'd64, 320);
        test_random_heap(11'd200, 320);
        test_random_heap(11'd1024, 30);

        repeat (20)
            @(posedge clk);
        $display("Sent %0d commands over heap sizes 0 to 2047, checked %0d results",
                 items_sent, results_seen);
        $display("Relocating resizes: %0d, frees with already free pages: %0d",
                 relocations_seen, double_frees_seen);
        if (failures == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
